// ===== design/ttsi_pkg.sv =====
// shared types and constants of the text to signed integer converter
package ttsi_pkg;

    // default bound on the consumed length
    localparam int unsigned TTSI_MAX_TEXT_LEN = 32'd65535;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 16;

    // input transaction payload
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              start_req;
    } ttsi_in_t;

    // result transaction payload
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      range_error;
        logic                      digits_seen;
        logic [POS_W-1:0]          end_offset;
    } ttsi_out_t;

    // datapath operations issued per character
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SKIP,
        OP_NEG,
        OP_ZERO,
        OP_HEX,
        OP_TAKE,
        OP_FINISH
    } ttsi_op_t;

    // command from controller to datapath
    typedef struct packed {
        ttsi_op_t op;
        logic     first_char;
    } ttsi_cmd_t;

    // character classification from datapath to controller
    typedef struct packed {
        logic start;
        logic is_space;
        logic is_minus;
        logic is_plus;
        logic zero_prefix;
        logic is_x;
        logic ok_first;
        logic ok_take;
    } ttsi_stat_t;

endpackage

// ===== design/ttsi_ctrl.sv =====
// conversion phase controller and handshake control
module ttsi_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  ttsi_pkg::ttsi_stat_t stat,
    output ttsi_pkg::ttsi_cmd_t  cmd
);
    import ttsi_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LEAD   = 6'b000010,
        ST_SIGNED = 6'b000100,
        ST_ZERO   = 6'b001000,
        ST_HEXPFX = 6'b010000,
        ST_DIGITS = 6'b100000
    } state_t;

    state_t state_reg, state_next, phase;
    logic   m_valid_reg, m_valid_next;
    logic   fire;

    // input taken whenever the result slot is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign fire    = s_valid && s_ready;
    assign phase   = stat.start ? ST_LEAD : state_reg;

    // phase transitions and datapath commands
    always_comb begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.first_char = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        if (fire) begin
            state_next = phase;
            case (phase)
                ST_IDLE: begin
                    state_next = ST_IDLE;
                end
                ST_LEAD, ST_SIGNED: begin
                    if (phase == ST_LEAD && stat.is_space) begin
                        cmd.op = OP_SKIP;
                    end else if (phase == ST_LEAD && stat.is_minus) begin
                        cmd.op     = OP_NEG;
                        state_next = ST_SIGNED;
                    end else if (phase == ST_LEAD && stat.is_plus) begin
                        cmd.op     = OP_SKIP;
                        state_next = ST_SIGNED;
                    end else if (stat.zero_prefix) begin
                        cmd.op     = OP_ZERO;
                        state_next = ST_ZERO;
                    end else begin
                        cmd.first_char = 1'b1;
                        if (stat.ok_first) begin
                            cmd.op     = OP_TAKE;
                            state_next = ST_DIGITS;
                        end else begin
                            cmd.op     = OP_FINISH;
                            state_next = ST_IDLE;
                        end
                    end
                end
                ST_ZERO, ST_HEXPFX, ST_DIGITS: begin
                    if (phase == ST_ZERO && stat.is_x) begin
                        cmd.op     = OP_HEX;
                        state_next = ST_HEXPFX;
                    end else if (stat.ok_take) begin
                        cmd.op     = OP_TAKE;
                        state_next = ST_DIGITS;
                    end else begin
                        cmd.op     = OP_FINISH;
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        if (cmd.op == OP_FINISH) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/ttsi_datapath.sv =====
// character classification, accumulator, position counter and result register
module ttsi_datapath #(
    parameter int unsigned MAX_TEXT_LEN = ttsi_pkg::TTSI_MAX_TEXT_LEN
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [ttsi_pkg::BASE_W-1:0] cfg_data,
    input  ttsi_pkg::ttsi_in_t          s_data,
    input  ttsi_pkg::ttsi_cmd_t         cmd,
    output ttsi_pkg::ttsi_stat_t        stat,
    output ttsi_pkg::ttsi_out_t         m_data
);
    import ttsi_pkg::*;

    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_SEEN = 2'd1,
        DS_OVF  = 2'd2
    } dstat_t;

    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_TEXT_LEN > 32'd65535) ? 16'hFFFF : POS_W'(MAX_TEXT_LEN);

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    localparam logic [BASE_W-1:0] NO_DIGIT = '1;
    localparam logic [BASE_W-1:0] BASE_2   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_8   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_10  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_16  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_36  = 6'd36;

    localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    localparam int WIDE_W = VALUE_W + BASE_W;

    // digit value of a character, all ones when it is no digit
    function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        begin
            t = '0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                t = c - CH_ZERO;
            end else if (c >= CH_UA && c <= CH_UZ) begin
                t = c - CH_UA + 8'd10;
            end else if (c >= CH_LA && c <= CH_LZ) begin
                t = c - CH_LA + 8'd10;
            end else begin
                t = {2'b00, NO_DIGIT};
            end
            digit_of = t[BASE_W-1:0];
        end
    endfunction

    function automatic logic base_ok(input logic [BASE_W-1:0] b);
        base_ok = (b >= BASE_2) && (b <= BASE_36);
    endfunction

    logic [BASE_W-1:0]  number_base_reg;
    logic [BASE_W-1:0]  active_base_reg, active_base_next;
    logic               negative_reg, negative_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    dstat_t             dstat_reg, dstat_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    ttsi_out_t          result_reg, result_next;

    logic [BASE_W-1:0]  base_cur, first_base, take_base, digit;
    logic               neg_cur;
    logic [VALUE_W-1:0] acc_cur, cut;
    dstat_t             dstat_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [WIDE_W-1:0]  prod, sum;
    logic               overflow;

    // state as seen by this character, cleared on a start request that also reloads the configured base
    assign base_cur  = s_data.start_req ? number_base_reg : active_base_reg;
    assign neg_cur   = s_data.start_req ? 1'b0 : negative_reg;
    assign acc_cur   = s_data.start_req ? '0 : acc_reg;
    assign dstat_cur = s_data.start_req ? DS_NONE : dstat_reg;
    assign pos_cur   = s_data.start_req ? '0 : pos_reg;

    // bases used for the first digit candidate and for later ones
    assign first_base = (base_cur == '0) ? BASE_10 : base_cur;
    assign take_base  = cmd.first_char ? first_base : base_cur;
    assign digit      = digit_of(s_data.ch);

    // character classification
    always_comb begin
        stat.start       = s_data.start_req;
        stat.is_space    = (s_data.ch == CH_SPACE) ||
                           (s_data.ch >= CH_TAB && s_data.ch <= CH_CR);
        stat.is_minus    = (s_data.ch == CH_MINUS);
        stat.is_plus     = (s_data.ch == CH_PLUS);
        stat.zero_prefix = (s_data.ch == CH_ZERO) &&
                           ((base_cur == '0) || (base_cur == BASE_16));
        stat.is_x        = (s_data.ch == CH_LX) || (s_data.ch == CH_UX);
        stat.ok_first    = base_ok(first_base) && (digit < first_base);
        stat.ok_take     = base_ok(base_cur) && (digit < base_cur);
    end

    // multiply-accumulate with overflow test against the signed bound
    assign cut      = neg_cur ? NEG_MIN : POS_MAX;
    assign prod     = WIDE_W'(acc_cur) * WIDE_W'(take_base);
    assign sum      = prod + WIDE_W'(digit);
    assign overflow = (dstat_cur == DS_OVF) || (sum > {{BASE_W{1'b0}}, cut});

    // next state per command
    always_comb begin
        active_base_next = active_base_reg;
        negative_next    = negative_reg;
        acc_next         = acc_reg;
        dstat_next       = dstat_reg;
        pos_next         = pos_reg;
        result_next      = result_reg;
        if (cmd.op != OP_NONE) begin
            active_base_next = base_cur;
            negative_next    = neg_cur;
            acc_next         = acc_cur;
            dstat_next       = dstat_cur;
            pos_next         = (pos_cur < POS_CAP) ? pos_cur + POS_W'(1) : pos_cur;
        end
        case (cmd.op)
            OP_NONE, OP_SKIP: begin
            end
            OP_NEG: begin
                negative_next = 1'b1;
            end
            OP_ZERO: begin
                active_base_next = (base_cur == '0) ? BASE_8 : BASE_16;
                acc_next         = '0;
                dstat_next       = DS_SEEN;
            end
            OP_HEX: begin
                active_base_next = BASE_16;
                acc_next         = '0;
                dstat_next       = DS_NONE;
            end
            OP_TAKE: begin
                active_base_next = take_base;
                if (overflow) begin
                    dstat_next = DS_OVF;
                end else begin
                    acc_next   = sum[VALUE_W-1:0];
                    dstat_next = DS_SEEN;
                end
            end
            OP_FINISH: begin
                if (dstat_cur == DS_OVF) begin
                    result_next.value = cut;
                end else begin
                    result_next.value = neg_cur ? -acc_cur : acc_cur;
                end
                result_next.range_error = (dstat_cur == DS_OVF);
                result_next.digits_seen = (dstat_cur != DS_NONE);
                result_next.end_offset  = (dstat_cur != DS_NONE) ? pos_cur : '0;
            end
            default: begin
            end
        endcase
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= '0;
            active_base_reg <= '0;
            negative_reg    <= 1'b0;
            acc_reg         <= '0;
            dstat_reg       <= DS_NONE;
            pos_reg         <= '0;
        end else begin
            if (cfg_valid) begin
                number_base_reg <= cfg_data;
            end
            active_base_reg <= active_base_next;
            negative_reg    <= negative_next;
            acc_reg         <= acc_next;
            dstat_reg       <= dstat_next;
            pos_reg         <= pos_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_data = result_reg;

endmodule

// ===== design/text_to_signed_integer_saturating.sv =====
// top level of the streaming text to signed 64-bit integer converter
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      ch, start_req
//   m_       out        m_valid / m_ready      value, range_error, digits_seen, end_offset
//   cfg_     in         cfg_valid / cfg_ready  number_base (6 bits)
//
// one character per cycle while s_ready is high; the digit multiply-accumulate and overflow test
// complete in the cycle the character is taken
// a result appears in the output register the cycle after its terminating character
// s_ready drops only while a result waits and m_ready is low
// cfg_ready is always high; synchronous active-low reset clears base and phase
module text_to_signed_integer_saturating #(
    parameter int unsigned MAX_TEXT_LEN = ttsi_pkg::TTSI_MAX_TEXT_LEN
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ttsi_pkg::BASE_W-1:0] cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ttsi_pkg::ttsi_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ttsi_pkg::ttsi_out_t         m_data
);
    import ttsi_pkg::*;

    ttsi_cmd_t  cmd;
    ttsi_stat_t stat;

    assign cfg_ready = 1'b1;

    // phase controller
    ttsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // accumulator and result datapath
    ttsi_datapath #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

// ===== tb/sv/ttsi_result_checker.sv =====
// checker that predicts and compares the converter's result transactions
module ttsi_result_checker #(
    parameter int unsigned MAX_TEXT_LEN = ttsi_pkg::TTSI_MAX_TEXT_LEN
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [ttsi_pkg::BASE_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  ttsi_pkg::ttsi_in_t          s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  ttsi_pkg::ttsi_out_t         m_data,
    input  logic                        end_of_test,
    output int unsigned                 fail_count,
    output int unsigned                 pending_count
);
    import ttsi_pkg::*;

    // offset bound and saturation values
    localparam int unsigned POS_CAP = (MAX_TEXT_LEN > 32'd65535) ? 32'd65535 : MAX_TEXT_LEN;
    localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_NEG = 64'h8000_0000_0000_0000;
    localparam int unsigned NO_DIGIT = 99;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LZ    = "z";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_SIGNED,
        SCAN_ZERO,
        SCAN_HEXPFX,
        SCAN_DIGITS
    } scan_phase_t;

    typedef enum logic [1:0] {
        DIG_NONE,
        DIG_SEEN,
        DIG_OVF
    } digit_state_t;

    // predicted converter state
    logic [BASE_W-1:0]  base_setting;
    scan_phase_t        scan_phase;
    logic               is_negative;
    logic [63:0]        magnitude;
    digit_state_t       digit_state;
    logic [BASE_W-1:0]  radix;
    logic [63:0]        cut_quotient;
    logic [BASE_W-1:0]  cut_remainder;
    logic [POS_W-1:0]   char_offset;
    logic               leftovers_checked;

    // converted numbers still owed by the block, oldest first
    ttsi_out_t numbers_due[$];

    function automatic int unsigned char_weight(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
        return NO_DIGIT;
    endfunction

    function automatic bit radix_ok(input logic [BASE_W-1:0] b);
        return b >= 6'd2 && b <= 6'd36;
    endfunction

    // fix the radix and the overflow threshold for the current sign
    task automatic set_radix(input logic [BASE_W-1:0] b);
        logic [63:0] cut;
        cut = is_negative ? MAX_NEG : MAX_POS;
        radix = b;
        if (radix_ok(b)) begin
            cut_remainder = BASE_W'(cut % 64'(b));
            cut_quotient  = cut / 64'(b);
        end else begin
            cut_remainder = '0;
            cut_quotient  = '0;
        end
    endtask

    // conversion ends: queue the number it yields
    task automatic close_number();
        ttsi_out_t num;
        if (digit_state == DIG_OVF)
            num.value = is_negative ? MAX_NEG : MAX_POS;
        else
            num.value = is_negative ? 64'd0 - magnitude : magnitude;
        num.range_error = (digit_state == DIG_OVF);
        num.digits_seen = (digit_state != DIG_NONE);
        num.end_offset  = (digit_state != DIG_NONE) ? char_offset : '0;
        numbers_due.push_back(num);
        scan_phase = SCAN_IDLE;
    endtask

    // digit candidate: accumulate with saturation or end the conversion
    task automatic take_digit(input logic [7:0] c);
        int unsigned d;
        d = char_weight(c);
        if (!radix_ok(radix) || d >= radix) begin
            close_number();
            return;
        end
        if (digit_state == DIG_OVF || magnitude > cut_quotient ||
            (magnitude == cut_quotient && d > cut_remainder)) begin
            digit_state = DIG_OVF;
        end else begin
            magnitude   = magnitude * 64'(radix) + 64'(d);
            digit_state = DIG_SEEN;
        end
        scan_phase = SCAN_DIGITS;
    endtask

    // first character after blanks and sign; a leading zero may open a prefix
    task automatic open_number(input logic [7:0] c);
        logic [BASE_W-1:0] b;
        b = radix;
        if (c == CH_ZERO && (b == 6'd0 || b == 6'd16)) begin
            set_radix(b == 6'd0 ? 6'd8 : 6'd16);
            magnitude   = '0;
            digit_state = DIG_SEEN;
            scan_phase  = SCAN_ZERO;
        end else begin
            set_radix(b == 6'd0 ? 6'd10 : b);
            take_digit(c);
        end
    endtask

    // advance the predicted converter by one accepted character
    task automatic convert_char(input ttsi_in_t item);
        logic is_blank;
        is_blank = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
        if (item.start_req) begin
            scan_phase    = SCAN_LEAD;
            is_negative   = 1'b0;
            magnitude     = '0;
            digit_state   = DIG_NONE;
            radix         = base_setting;
            cut_quotient  = '0;
            cut_remainder = '0;
            char_offset   = '0;
        end
        if (scan_phase == SCAN_IDLE) return;
        case (scan_phase)
            SCAN_LEAD: begin
                if (!is_blank) begin
                    if (item.ch == CH_MINUS) begin
                        is_negative = 1'b1;
                        scan_phase  = SCAN_SIGNED;
                    end else if (item.ch == CH_PLUS) begin
                        scan_phase = SCAN_SIGNED;
                    end else begin
                        open_number(item.ch);
                    end
                end
            end
            SCAN_SIGNED: begin
                open_number(item.ch);
            end
            SCAN_ZERO: begin
                if (item.ch == CH_LX || item.ch == CH_UX) begin
                    set_radix(6'd16);
                    magnitude   = '0;
                    digit_state = DIG_NONE;
                    scan_phase  = SCAN_HEXPFX;
                end else begin
                    take_digit(item.ch);
                end
            end
            default: begin
                take_digit(item.ch);
            end
        endcase
        if (char_offset < POS_CAP) char_offset = char_offset + POS_W'(1);
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        int unsigned new_fails;
        ttsi_out_t   want;
        new_fails = 0;
        if (!aresetn) begin
            base_setting      = '0;
            scan_phase        = SCAN_IDLE;
            is_negative       = 1'b0;
            magnitude         = '0;
            digit_state       = DIG_NONE;
            radix             = '0;
            cut_quotient      = '0;
            cut_remainder     = '0;
            char_offset       = '0;
            leftovers_checked = 1'b0;
            numbers_due.delete();
        end else begin
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (numbers_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0h",
                             $time, m_data.value);
                    new_fails++;
                end else begin
                    want = numbers_due.pop_front();
                    if (m_data.value !== want.value) begin
                        report_field("value", want.value, m_data.value);
                        new_fails++;
                    end
                    if (m_data.range_error !== want.range_error) begin
                        report_field("range_error", 64'(want.range_error),
                                     64'(m_data.range_error));
                        new_fails++;
                    end
                    if (m_data.digits_seen !== want.digits_seen) begin
                        report_field("digits_seen", 64'(want.digits_seen),
                                     64'(m_data.digits_seen));
                        new_fails++;
                    end
                    if (m_data.end_offset !== want.end_offset) begin
                        report_field("end_offset", 64'(want.end_offset),
                                     64'(m_data.end_offset));
                        new_fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) base_setting = cfg_data;
            if (s_valid && s_ready) convert_char(s_data);
            // anything still owed at the end is missing
            if (end_of_test && !leftovers_checked) begin
                while (numbers_due.size() != 0) begin
                    want = numbers_due.pop_front();
                    $display("%0t: missing result, expected value %0h, actual none",
                             $time, want.value);
                    new_fails++;
                end
                leftovers_checked = 1'b1;
            end
        end
        if (!aresetn)
            fail_count <= 0;
        else
            fail_count <= fail_count + new_fails;
        pending_count <= numbers_due.size();
    end

endmodule

// ===== tb/sv/text_to_signed_integer_saturating_test.sv =====
// testbench top: stimulus, idling and verdict for the text to integer converter
module text_to_signed_integer_saturating_test;
    import ttsi_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned QUIET_CYCLES = 6;
    localparam int unsigned END_CYCLES   = 20;
    localparam int unsigned CHUNK_CHARS  = 50;
    localparam int unsigned LONG_ZEROS   = 40;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_UX    = "X";

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [BASE_W-1:0] cfg_data    = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    ttsi_in_t          s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    ttsi_out_t         m_data;
    logic              end_of_test = 1'b0;
    int unsigned       fail_count;
    int unsigned       pending_count;

    // stimulus control
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;
    int unsigned       holds_asked   = 0;
    int unsigned       holds_done    = 0;
    int unsigned       hold_left     = 0;
    int unsigned       stall_cycles  = 0;
    int unsigned       chars_sent    = 0;
    logic [BASE_W-1:0] cfg_base      = '0;
    logic              opening       = 1'b0;

    text_to_signed_integer_saturating DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ttsi_result_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .end_of_test   (end_of_test),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    always #1 aclk = ~aclk;

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_asked != holds_done) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("text_to_signed_integer_saturating_test: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [7:0] blank_char(input int unsigned idx);
        return (idx < 5) ? 8'(8'h09 + idx) : 8'h20;
    endfunction

    // one input transaction, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] c, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{ch: c, start_req: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic put_char(input logic [7:0] c);
        send_char(c, opening);
        opening = 1'b0;
    endtask

    task automatic send_text(input string txt, input bit fresh, input bit terminate);
        if (fresh) opening = 1'b1;
        for (int i = 0; i < txt.len(); i++) put_char(8'(txt[i]));
        if (terminate) put_char(CH_NUL);
    endtask

    // close any open conversion, drain, then write the base register
    task automatic settle_and_set_base(input logic [BASE_W-1:0] b);
        send_char(CH_NUL, 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= b;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        cfg_base = b;
    endtask

    // mostly well-formed numbers with random content, some noise and stray bytes
    task automatic send_random_number();
        int unsigned kind;
        int unsigned r;
        int unsigned eff;
        int unsigned n_digits;
        int unsigned v;
        int unsigned mark;
        kind = $urandom_range(99);
        if (kind < 75) begin
            opening = 1'b1;
            repeat ($urandom_range(0, 2)) put_char(blank_char($urandom_range(5)));
            r = $urandom_range(3);
            if (r == 0) put_char(CH_MINUS);
            else if (r == 1) put_char(CH_PLUS);
            // optional prefix, and the base the digits should follow
            eff = cfg_base;
            r = $urandom_range(9);
            if (r < 3 && (cfg_base == 0 || cfg_base == 16)) begin
                put_char(CH_ZERO);
                put_char($urandom_range(1) ? CH_LX : CH_UX);
                eff = 16;
            end else if (r < 5 && cfg_base == 0) begin
                put_char(CH_ZERO);
                eff = 8;
            end else if (cfg_base == 0) begin
                eff = 10;
            end
            r = $urandom_range(99);
            n_digits = (r < 5)  ? 0 :
                       (r < 75) ? $urandom_range(1, 6) :
                       (r < 94) ? $urandom_range(15, 22) : $urandom_range(60, 66);
            repeat (n_digits) begin
                if (eff < 2 || eff > 36 || $urandom_range(49) == 0)
                    v = $urandom_range(35);
                else
                    v = $urandom_range(eff - 1);
                if (v < 10)
                    put_char(8'(CH_ZERO + v));
                else if ($urandom_range(1))
                    put_char(8'(CH_LA + v - 10));
                else
                    put_char(8'(CH_UA + v - 10));
            end
            // terminator that is never a letter or digit
            case ($urandom_range(5))
                0:       put_char(CH_NUL);
                1:       put_char(8'($urandom_range(128, 255)));
                2:       put_char(8'($urandom_range(1, 47)));
                3:       put_char(8'($urandom_range(58, 64)));
                4:       put_char(8'($urandom_range(91, 96)));
                default: put_char(8'($urandom_range(123, 127)));
            endcase
        end else if (kind < 90) begin
            // random bytes with occasional restarts
            opening = 1'b1;
            repeat ($urandom_range(1, 6)) begin
                put_char(8'($urandom_range(255)));
                if ($urandom_range(7) == 0) opening = 1'b1;
            end
            put_char(CH_NUL);
        end else begin
            // bytes without a start while idle do not count
            mark = chars_sent;
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
            chars_sent = mark;
        end
    endtask

    // main sequence
    initial begin
        int unsigned chunk_start;
        logic [BASE_W-1:0] next_base;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: blanks, sign, extremes, prefixes and special cases
        settle_and_set_base(6'd0);
        opening = 1'b1;
        for (int i = 0; i < 6; i++) put_char(blank_char(i));
        send_text("+123", 0, 1);
        send_text("9223372036854775807", 1, 1);
        send_text("-9223372036854775808", 1, 1);
        send_text("9223372036854775808", 1, 1);
        send_text("-9223372036854775809", 1, 1);
        send_text("0x", 1, 0);
        put_char("g");
        send_text("-0X7fFfffffffffffff", 1, 1);
        send_text("0777", 1, 0);
        put_char("8");
        send_text("-", 1, 1);
        // restart in the middle of a number
        send_text("12", 1, 0);
        send_text("-34", 1, 1);
        // bytes while idle, then high bytes
        send_text("77", 0, 0);
        opening = 1'b1;
        put_char(8'hFF);
        send_text("5", 1, 0);
        put_char(8'hA5);
        settle_and_set_base(6'd36);
        send_text("zZ9", 1, 1);
        send_text("zzzzzzzzzzzzzz", 1, 1);
        settle_and_set_base(6'd2);
        send_text("-1011", 1, 0);
        put_char("2");
        settle_and_set_base(6'd16);
        send_text("0xFFFFFFFFFFFFFFFF", 1, 1);
        send_text("-0x8000000000000000", 1, 1);
        send_text("0x", 1, 1);
        // bases outside 2..36 take no digit
        settle_and_set_base(6'd1);
        send_text("5", 1, 1);
        settle_and_set_base(6'd63);
        send_text("-7", 1, 1);
        settle_and_set_base(6'd37);
        send_text(" 0", 1, 1);
        settle_and_set_base(6'd8);
        send_text("0x1", 1, 1);

        // long run of zeros: value overflows and the conversion keeps going
        settle_and_set_base(6'd10);
        opening = 1'b1;
        put_char("1");
        repeat (LONG_ZEROS) put_char(CH_ZERO);
        put_char(CH_NUL);

        // random: receiver idles more, then sender idles more, then neither
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 47 : 0;
            recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 35 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                case ($urandom_range(9))
                    0, 1, 2: next_base = 6'd0;
                    3:       next_base = 6'd10;
                    4:       next_base = 6'd16;
                    5:       next_base = 6'd2;
                    6:       next_base = 6'd36;
                    7:       next_base = 6'd8;
                    8:       next_base = 6'($urandom_range(63));
                    default: next_base = 6'($urandom_range(2, 36));
                endcase
                settle_and_set_base(next_base);
                // long receiver hold-off while the sender keeps going
                if (chunk == 1) holds_asked++;
                chunk_start = chars_sent;
                while (chars_sent - chunk_start < CHUNK_CHARS) send_random_number();
            end
        end

        // drain and decide
        send_char(CH_NUL, 1'b0);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge aclk);
        if (fail_count == 0)
            $display("text_to_signed_integer_saturating_test: clean");
        else
            $display("text_to_signed_integer_saturating_test: errors");
        $finish;
    end

endmodule
